/* design/haversine_distance_assert.svh */
// assertion macros shared by the checker
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// same-cycle implication
`define HVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("haversine_distance check failed");

// next-cycle implication
`define HVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("haversine_distance check failed");

`endif

/* design/hvd_pkg.sv */
package hvd_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int ANG_W = 34;

    typedef logic signed [ANG_W-1:0] cval_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
    } cordic_t;

    localparam logic signed [32:0] FULL_UNITS = 33'sd1509949440;
    localparam logic signed [32:0] HALF_UNITS = 33'sd754974720;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [33:0] RAD_SCALE = 34'd9595049034;
    localparam int RAD_SPLIT = 17;
    localparam logic [16:0] RAD_LO = RAD_SCALE[16:0];
    localparam logic [16:0] RAD_HI = RAD_SCALE[33:17];
    localparam cval_t ROT_START = 34'sd652032874;
    localparam logic [32:0] DIST_MAX = 33'd6746000000;
    localparam logic [22:0] RADIUS_RESET = 23'd6378137;

    localparam int FRONT_LAT = CORDIC_STAGES + 6;
    localparam int HAV_LAT = 4;
    localparam int RAD_W = 62;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int VEC_LAT = CORDIC_STAGES + 3;

    // atan(2^-i) in radians q30
    function automatic cval_t atan_q30(input int i);
        cval_t r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = (i <= 30) ? (cval_t'(1) <<< (30 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

/* design/hvd_in_if.sv */
interface hvd_in_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_a;
    logic signed [30:0] lon_b;
    logic signed [29:0] lat_b;
    logic [30:0]        cos_lat_a;
    logic [30:0]        cos_lat_b;

    modport source (output valid, lon_a, lat_a, lon_b, lat_b, cos_lat_a, cos_lat_b,
                    input ready);
    modport sink (input valid, lon_a, lat_a, lon_b, lat_b, cos_lat_a, cos_lat_b,
                  output ready);
endinterface

/* design/hvd_cfg_if.sv */
interface hvd_cfg_if;
    logic        valid;
    logic        ready;
    logic [22:0] sphere_radius;

    modport source (output valid, sphere_radius, input ready);
    modport sink (input valid, sphere_radius, output ready);
endinterface

/* design/hvd_out_if.sv */
interface hvd_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

/* design/hvd_front.sv */
module hvd_front import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_b,
    input  logic signed [29:0] lat_b,
    input  logic [30:0]        cos_lat_a,
    input  logic [30:0]        cos_lat_b,
    output logic               out_valid,
    output logic [30:0]        sin_lon,
    output logic [30:0]        sin_lat,
    output logic [31:0]        cos_prod
);

    logic [FRONT_LAT-1:0] v_reg;
    logic [31:0]          cc_reg [FRONT_LAT];
    logic [61:0]          cc_full;
    logic signed [32:0]   d_next [2];

    logic signed [32:0] d_reg  [2];
    logic [30:0]        r_reg  [2];
    logic [29:0]        f_reg  [2];
    logic [46:0]        ph_reg [2];
    logic [46:0]        pl_reg [2];
    logic [30:0]        th_reg [2];
    cordic_t            cr_reg [2][CORDIC_STAGES];
    logic [30:0]        mag_reg [2];

    assign d_next[0] = 33'(lon_b) - 33'(lon_a);
    assign d_next[1] = 33'(lat_b) - 33'(lat_a);
    assign cc_full   = 62'(cos_lat_a) * 62'(cos_lat_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg[0] <= cc_full[61:30];
            for (int k = 1; k < FRONT_LAT; k++)
            begin
                cc_reg[k] <= cc_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [33:0] dm;
        logic signed [33:0] dm2;
        logic signed [33:0] dp;
        logic signed [33:0] r_sel;
        logic [30:0]        f_sel;
        logic [65:0]        t_sum;
        logic signed [ANG_W-1:0] ay;
        cordic_t            last;

        always_comb
        begin
            dm  = 34'(d_reg[l]) + 34'(FULL_UNITS);
            dm2 = dm + 34'(FULL_UNITS);
            dp  = 34'(d_reg[l]) - 34'(FULL_UNITS);
            if (d_reg[l] < 0)
            begin
                r_sel = (dm < 0) ? dm2 : dm;
            end
            else
            begin
                r_sel = (34'(d_reg[l]) >= 34'(FULL_UNITS)) ? dp : 34'(d_reg[l]);
            end
            f_sel = (r_reg[l] > 31'(HALF_UNITS)) ? 31'(FULL_UNITS) - r_reg[l] : r_reg[l];
            t_sum = (66'(ph_reg[l]) << RAD_SPLIT) + 66'(pl_reg[l]) + (66'd1 << 31);
            last  = cr_reg[l][CORDIC_STAGES-1];
            ay    = last.y[ANG_W-1] ? -last.y : last.y;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[l]  <= d_next[l];
                r_reg[l]  <= r_sel[30:0];
                f_reg[l]  <= f_sel[29:0];
                ph_reg[l] <= 47'(f_reg[l]) * 47'(RAD_HI);
                pl_reg[l] <= 47'(f_reg[l]) * 47'(RAD_LO);
                th_reg[l] <= t_sum[62:32];
                mag_reg[l] <= (ay > cval_t'(ONE_Q30)) ? ONE_Q30 : ay[30:0];
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            cordic_t cur;
            cordic_t nxt;

            always_comb
            begin
                if (i == 0)
                begin
                    cur.x = ROT_START;
                    cur.y = '0;
                    cur.z = cval_t'({3'b000, th_reg[l]});
                end
                else
                begin
                    cur = cr_reg[l][(i == 0) ? 0 : i - 1];
                end
                if (!cur.z[ANG_W-1])
                begin
                    nxt.x = cur.x - (cur.y >>> i);
                    nxt.y = cur.y + (cur.x >>> i);
                    nxt.z = cur.z - atan_q30(i);
                end
                else
                begin
                    nxt.x = cur.x + (cur.y >>> i);
                    nxt.y = cur.y - (cur.x >>> i);
                    nxt.z = cur.z + atan_q30(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cr_reg[l][i] <= nxt;
                end
            end
        end
    end

    assign out_valid = v_reg[FRONT_LAT-1];
    assign sin_lon   = mag_reg[0];
    assign sin_lat   = mag_reg[1];
    assign cos_prod  = cc_reg[FRONT_LAT-1];

endmodule

/* design/hvd_hav.sv */
module hvd_hav import hvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] sin_lon,
    input  logic [30:0] sin_lat,
    input  logic [31:0] cos_prod,
    output logic        out_valid,
    output logic [30:0] h_sin,
    output logic [30:0] h_cos
);

    logic [HAV_LAT-1:0] v_reg;
    logic [30:0] sx2_reg;
    logic [30:0] sy2_reg;
    logic [31:0] cc_reg;
    logic [32:0] p_reg;
    logic [30:0] sy2d_reg;
    logic [30:0] h_reg;
    logic [30:0] hs_reg;
    logic [30:0] hc_reg;

    logic [61:0] sx_sq;
    logic [61:0] sy_sq;
    logic [62:0] p_full;
    logic [33:0] h_sum;

    always_comb
    begin
        sx_sq  = 62'(sin_lon) * 62'(sin_lon);
        sy_sq  = 62'(sin_lat) * 62'(sin_lat);
        p_full = 63'(cc_reg) * 63'(sx2_reg);
        h_sum  = 34'(sy2d_reg) + 34'(p_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[HAV_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx2_reg  <= sx_sq[60:30];
            sy2_reg  <= sy_sq[60:30];
            cc_reg   <= cos_prod;
            p_reg    <= p_full[62:30];
            sy2d_reg <= sy2_reg;
            h_reg    <= (h_sum > 34'(ONE_Q30)) ? ONE_Q30 : h_sum[30:0];
            hs_reg   <= h_reg;
            hc_reg   <= ONE_Q30 - h_reg;
        end
    end

    assign out_valid = v_reg[HAV_LAT-1];
    assign h_sin     = hs_reg;
    assign h_cos     = hc_reg;

endmodule

/* design/hvd_isqrt.sv */
module hvd_isqrt import hvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] value,
    output logic        out_valid,
    output logic [30:0] root
);

    logic [SQRT_STEPS-1:0] v_reg;
    logic [RAD_W-1:0] rad_reg  [SQRT_STEPS];
    logic [32:0]      rem_reg  [SQRT_STEPS];
    logic [30:0]      root_reg [SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    // one result bit per stage, two radicand bits shifted in
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [RAD_W-1:0] rad_in;
        logic [32:0]      rem_in;
        logic [30:0]      root_in;
        logic [34:0]      rem_t;
        logic [34:0]      trial;

        always_comb
        begin
            if (k == 0)
            begin
                rad_in  = RAD_W'({value, 30'b0});
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = rad_reg[(k == 0) ? 0 : k - 1];
                rem_in  = rem_reg[(k == 0) ? 0 : k - 1];
                root_in = root_reg[(k == 0) ? 0 : k - 1];
            end
            rem_t = {rem_in[32:0], rad_in[RAD_W-1:RAD_W-2]};
            trial = {2'b00, root_in, 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= rad_in << 2;
                if (rem_t >= trial)
                begin
                    rem_reg[k]  <= 33'(rem_t - trial);
                    root_reg[k] <= {root_in[29:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_t[32:0];
                    root_reg[k] <= {root_in[29:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];

endmodule

/* design/hvd_vector.sv */
module hvd_vector import hvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] c_in,
    input  logic [30:0] s_in,
    input  logic [22:0] radius,
    output logic        out_valid,
    output logic [32:0] distance
);

    logic [VEC_LAT-1:0] v_reg;
    cordic_t            cr_reg [CORDIC_STAGES];
    logic [30:0]        ang_reg;
    logic [53:0]        prod_reg;
    logic [32:0]        dist_reg;
    cordic_t            last;

    assign last = cr_reg[CORDIC_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[VEC_LAT-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        cordic_t cur;
        cordic_t nxt;

        always_comb
        begin
            if (i == 0)
            begin
                cur.x = cval_t'({3'b000, c_in});
                cur.y = cval_t'({3'b000, s_in});
                cur.z = '0;
            end
            else
            begin
                cur = cr_reg[(i == 0) ? 0 : i - 1];
            end
            if (!cur.y[ANG_W-1])
            begin
                nxt.x = cur.x + (cur.y >>> i);
                nxt.y = cur.y - (cur.x >>> i);
                nxt.z = cur.z + atan_q30(i);
            end
            else
            begin
                nxt.x = cur.x - (cur.y >>> i);
                nxt.y = cur.y + (cur.x >>> i);
                nxt.z = cur.z - atan_q30(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_reg[i] <= nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg  <= last.z[ANG_W-1] ? '0 : last.z[30:0];
            prod_reg <= 54'(radius) * 54'(ang_reg);
            dist_reg <= (prod_reg[53:21] > DIST_MAX) ? DIST_MAX : prod_reg[53:21];
        end
    end

    assign out_valid = v_reg[VEC_LAT-1];
    assign distance  = dist_reg;

endmodule

/* design/haversine_distance.sv */
// haversine_distance: great-circle distance between two points, one per beat.
// src carries lon_a, lat_a, lon_b, lat_b (signed degrees, 22 fraction bits)
// and cos_lat_a, cos_lat_b (q30). dst returns distance in metres, 8 fraction
// bits, saturated at 6746000000. cfg writes sphere_radius (metres); write it
// only while no beat is in flight. cfg.ready is always high.
// Throughput: one beat per cycle while the output buffer is not full.
// A beat passes the 24-stage cordic pipelines of the front end and the vector
// unit and the 31-stage square root pipelines.
// All stages move together; the last stage feeds a two-entry output buffer,
// so a beat is still taken while one result waits at dst. When the receiver
// stalls and both entries fill, src.ready drops and the pipeline holds; no
// beat is lost or repeated.
// Reset clears all valid bits and the buffer and loads radius 6378137;
// src.ready is high right after reset.
module haversine_distance import hvd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hvd_in_if.sink     src,
    hvd_cfg_if.sink    cfg,
    hvd_out_if.source  dst
);

    logic [22:0] radius_reg;
    logic        en;

    logic        fr_valid;
    logic [30:0] sin_lon;
    logic [30:0] sin_lat;
    logic [31:0] cos_prod;
    logic        hv_valid;
    logic [30:0] h_sin;
    logic [30:0] h_cos;
    logic        s_valid;
    logic        c_valid;
    logic [30:0] s_root;
    logic [30:0] c_root;
    logic        vc_valid;
    logic [32:0] vc_dist;

    logic [32:0] buf_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        pop;

    assign en        = (fill_reg != 2'd2);
    assign src.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.sphere_radius;
        end
    end

    hvd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (src.valid),
        .lon_a     (src.lon_a),
        .lat_a     (src.lat_a),
        .lon_b     (src.lon_b),
        .lat_b     (src.lat_b),
        .cos_lat_a (src.cos_lat_a),
        .cos_lat_b (src.cos_lat_b),
        .out_valid (fr_valid),
        .sin_lon   (sin_lon),
        .sin_lat   (sin_lat),
        .cos_prod  (cos_prod)
    );

    hvd_hav u_hav (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .sin_lon   (sin_lon),
        .sin_lat   (sin_lat),
        .cos_prod  (cos_prod),
        .out_valid (hv_valid),
        .h_sin     (h_sin),
        .h_cos     (h_cos)
    );

    hvd_isqrt u_sqrt_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv_valid),
        .value     (h_sin),
        .out_valid (s_valid),
        .root      (s_root)
    );

    hvd_isqrt u_sqrt_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv_valid),
        .value     (h_cos),
        .out_valid (c_valid),
        .root      (c_root)
    );

    hvd_vector u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid & c_valid),
        .c_in      (c_root),
        .s_in      (s_root),
        .radius    (radius_reg),
        .out_valid (vc_valid),
        .distance  (vc_dist)
    );

    // output buffer
    assign push = en & vc_valid;
    assign pop  = dst.valid & dst.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= vc_dist;
        end
    end

    assign dst.valid    = (fill_reg != 2'd0);
    assign dst.distance = buf_reg[rd_ptr_reg];

endmodule

/* design/hvd_checker.sv */
`include "haversine_distance_assert.svh"

module hvd_checker import hvd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        src_valid,
    input logic        src_ready,
    input logic        dst_valid,
    input logic        dst_ready,
    input logic [32:0] distance,
    input logic        cfg_ready
);

    `HVD_ASSERT_NEXT(a_out_hold, dst_valid && !dst_ready && !$isunknown(src_valid), dst_valid && $stable(distance))
    `HVD_ASSERT_IMP(a_dist_range, dst_valid, distance <= DIST_MAX)
    `HVD_ASSERT_IMP(a_full_shows, !src_ready, dst_valid)
    `HVD_ASSERT_IMP(a_cfg_open, rst_n, cfg_ready)

endmodule

bind haversine_distance hvd_checker u_hvd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src.valid),
    .src_ready (src.ready),
    .dst_valid (dst.valid),
    .dst_ready (dst.ready),
    .distance  (dst.distance),
    .cfg_ready (cfg.ready)
);
